>>> sv/clni_pkg.sv
// Shared types and codes for the character LCD nibble interface.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package clni_pkg;

   // Operation codes carried on the request cmd field
   typedef enum logic [4:0] {
      CMD_INIT       = 5'd0,
      CMD_CLEAR      = 5'd1,
      CMD_HOME       = 5'd2,
      CMD_CURSOR     = 5'd3,
      CMD_DISP_OFF   = 5'd4,
      CMD_DISP_ON    = 5'd5,
      CMD_CURS_OFF   = 5'd6,
      CMD_CURS_ON    = 5'd7,
      CMD_BLINK_OFF  = 5'd8,
      CMD_BLINK_ON   = 5'd9,
      CMD_SCROLL_L   = 5'd10,
      CMD_SCROLL_R   = 5'd11,
      CMD_ENTRY_LTR  = 5'd12,
      CMD_ENTRY_RTL  = 5'd13,
      CMD_AUTO_ON    = 5'd14,
      CMD_AUTO_OFF   = 5'd15,
      CMD_CHAR       = 5'd16,
      CMD_GLYPH_ADDR = 5'd17
   } cmd_type;

   localparam int unsigned MAX_ROWS_DEFAULT = 4;
   localparam int unsigned LINES_WIDTH      = 3;
   localparam logic [LINES_WIDTH-1:0] LINES_RESET = 3'd1;

   // Controller to datapath
   typedef struct packed {
      logic capture;  // latch the request word and update the flags
      logic load;     // move the current strobe into the output register
   } clni_ctl_type;

   // Datapath to controller
   typedef struct packed {
      logic cmd_known;  // request cmd decodes to a real operation
      logic last;       // current strobe is the final one of the word
   } clni_sts_type;

endpackage

>>> sv/clni_ctrl.sv
// Controller FSM for the character LCD nibble interface.
// Depends on clni_pkg; drives clni_dpath through clni_ctl_type.
`timescale 1ns / 1ps

module clni_ctrl
   import clni_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   input  clni_sts_type sts,
   output clni_ctl_type ctl
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EMIT = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      ctl          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && sts.cmd_known) begin
               ctl.capture = 1'b1;
               state_in    = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // advance only when the output slot is empty or draining
            if (slot_free) begin
               ctl.load     = 1'b1;
               rsp_valid_in = 1'b1;
               if (sts.last) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> sv/clni_dpath.sv
// Datapath for the character LCD nibble interface: flags, byte build,
// strobe counter and output register. Depends on clni_pkg.
`timescale 1ns / 1ps

module clni_dpath
   import clni_pkg::*;
#(
   parameter int unsigned MAX_ROWS = MAX_ROWS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [4:0]             req_cmd,
   input  logic [7:0]             req_value,
   input  logic [7:0]             req_row,
   input  logic                   csr_write,
   input  logic [LINES_WIDTH-1:0] csr_wdata,
   input  clni_ctl_type           ctl,
   output clni_sts_type           sts,
   output logic                   rsp_reg_select,
   output logic [3:0]             rsp_nibble,
   output logic                   rsp_settle_after,
   output logic                   rsp_last
);

   localparam logic [7:0] RowMax      = 8'(MAX_ROWS - 1);
   localparam logic [3:0] InitLastIdx = 4'd11;

   localparam logic [7:0] ByteClear   = 8'h01;
   localparam logic [7:0] ByteHome    = 8'h02;
   localparam logic [7:0] ByteEntry   = 8'h04;
   localparam logic [7:0] ByteDisplay = 8'h08;
   localparam logic [7:0] ByteScrollL = 8'h18;
   localparam logic [7:0] ByteScrollR = 8'h1C;
   localparam logic [7:0] ByteCgram   = 8'h40;
   localparam logic [7:0] ByteDdram   = 8'h80;

   typedef struct packed {
      logic       reg_select;
      logic [3:0] nibble;
      logic       settle;
      logic       last;
   } strobe_type;

   function automatic logic [7:0] row_base(input logic [1:0] r);
      logic [7:0] b;
      unique case (r)
         2'd0:    b = 8'd0;
         2'd1:    b = 8'd64;
         2'd2:    b = 8'd16;
         default: b = 8'd80;
      endcase
      return b;
   endfunction

   // Power-up sequence: wake nibbles, 4-bit switch, then four full bytes
   function automatic strobe_type init_strobe(input logic [3:0] idx);
      strobe_type s;
      s = '0;
      unique case (idx)
         4'd0, 4'd1, 4'd2: begin s.nibble = 4'h3; s.settle = 1'b1; end
         4'd3, 4'd4:       s.nibble = 4'h2;
         4'd7:             s.nibble = 4'hC;
         4'd9:             begin s.nibble = 4'h1; s.settle = 1'b1; end
         4'd11:            begin s.nibble = 4'h6; s.last = 1'b1; end
         default:          s.nibble = 4'h0;
      endcase
      return s;
   endfunction

   logic [LINES_WIDTH-1:0] lines_ff;
   logic [2:0]             dflags_ff, dflags_in;
   logic [1:0]             eflags_ff, eflags_in;
   logic [7:0]             byte_ff, byte_in;
   logic                   rs_ff, rs_in;
   logic                   settle_ff, settle_in;
   logic                   init_ff, init_in;
   logic [3:0]             idx_ff;
   logic                   known;
   logic [LINES_WIDTH-1:0] lines_eff;
   logic [7:0]             row_cap;
   logic [6:0]             cursor_addr;
   strobe_type             cur;

   // Clamp the cursor row, then form the display RAM address
   always_comb begin
      lines_eff = (lines_ff == '0) ? LINES_WIDTH'(1) : lines_ff;
      row_cap   = (req_row > RowMax) ? RowMax : req_row;
      if (row_cap >= 8'(lines_eff)) row_cap = 8'(lines_eff) - 8'd1;
      cursor_addr = 7'(req_value + row_base(row_cap[1:0]));
   end

   always_comb begin
      dflags_in = dflags_ff;
      eflags_in = eflags_ff;
      byte_in   = 8'h00;
      rs_in     = 1'b0;
      settle_in = 1'b0;
      init_in   = 1'b0;
      known     = 1'b1;
      unique case (req_cmd)
         CMD_INIT: begin
            init_in   = 1'b1;
            dflags_in = 3'b100;
            eflags_in = 2'b10;
         end
         CMD_CLEAR:    begin byte_in = ByteClear; settle_in = 1'b1; end
         CMD_HOME:     begin byte_in = ByteHome;  settle_in = 1'b1; end
         CMD_CURSOR:   byte_in = ByteDdram | {1'b0, cursor_addr};
         CMD_DISP_OFF: dflags_in = dflags_ff & 3'b011;
         CMD_DISP_ON:  dflags_in = dflags_ff | 3'b100;
         CMD_CURS_OFF: dflags_in = dflags_ff & 3'b101;
         CMD_CURS_ON:  dflags_in = dflags_ff | 3'b010;
         CMD_BLINK_OFF: dflags_in = dflags_ff & 3'b110;
         CMD_BLINK_ON: dflags_in = dflags_ff | 3'b001;
         CMD_SCROLL_L: byte_in = ByteScrollL;
         CMD_SCROLL_R: byte_in = ByteScrollR;
         CMD_ENTRY_LTR: eflags_in = eflags_ff | 2'b10;
         CMD_ENTRY_RTL: eflags_in = eflags_ff & 2'b01;
         CMD_AUTO_ON:  eflags_in = eflags_ff | 2'b01;
         CMD_AUTO_OFF: eflags_in = eflags_ff & 2'b10;
         CMD_CHAR:     begin byte_in = req_value; rs_in = 1'b1; end
         CMD_GLYPH_ADDR: byte_in = ByteCgram | {2'b00, req_value[2:0], 3'b000};
         default:      known = 1'b0;
      endcase
      // display and entry commands re-send the whole control byte
      if (req_cmd >= CMD_DISP_OFF && req_cmd <= CMD_BLINK_ON)
         byte_in = ByteDisplay | {5'b0, dflags_in};
      if (req_cmd >= CMD_ENTRY_LTR && req_cmd <= CMD_AUTO_OFF)
         byte_in = ByteEntry | {6'b0, eflags_in};
   end

   always_comb begin
      if (init_ff) begin
         cur = init_strobe(idx_ff);
      end else begin
         cur.reg_select = rs_ff;
         cur.nibble     = idx_ff[0] ? byte_ff[3:0] : byte_ff[7:4];
         cur.settle     = idx_ff[0] && settle_ff;
         cur.last       = idx_ff[0];
      end
   end

   assign sts.cmd_known = known;
   assign sts.last      = cur.last;

   always_ff @(posedge clock) begin
      if (reset) begin
         lines_ff  <= LINES_RESET;
         dflags_ff <= '0;
         eflags_ff <= '0;
         idx_ff    <= '0;
         init_ff   <= 1'b0;
      end else begin
         if (csr_write) lines_ff <= csr_wdata;
         if (ctl.capture) begin
            dflags_ff <= dflags_in;
            eflags_ff <= eflags_in;
            init_ff   <= init_in;
            idx_ff    <= '0;
         end else if (ctl.load && !(init_ff && idx_ff == InitLastIdx)) begin
            idx_ff <= idx_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         byte_ff   <= byte_in;
         rs_ff     <= rs_in;
         settle_ff <= settle_in;
      end
      if (ctl.load) begin
         rsp_reg_select   <= cur.reg_select;
         rsp_nibble       <= cur.nibble;
         rsp_settle_after <= cur.settle;
         rsp_last         <= cur.last;
      end
   end

endmodule

>>> sv/char_lcd_nibble_interface_unit.sv
// Top level of the character LCD nibble interface.
// Depends on clni_pkg, clni_ctrl and clni_dpath.
`timescale 1ns / 1ps
//
// Usage
//   req channel: one operation word per handshake (cmd, value, row).
//   rsp channel: one enable strobe per word delivered (reg_select, nibble,
//     settle_after, last); last marks the final strobe of an operation.
//   csr channel: writes lines_in_use; always ready, write only while idle.
// Sequence
//   A byte-sized operation is first accepted, then each nibble goes out in turn
//   through the output register. Init sends twelve strobes. The output register
//   takes one strobe per cycle while the receiver is ready and holds otherwise;
//   a new operation is taken once the final strobe of the previous one is
//   loaded, even while that strobe still waits.
//   Unknown cmd codes are accepted and produce nothing.
// Reset
//   Synchronous, active high: flags clear, lines_in_use returns to 1, the
//   output register empties. When the receiver stalls, the current strobe
//   holds and the sequencer waits.

module char_lcd_nibble_interface_unit
   import clni_pkg::*;
#(
   parameter int unsigned MAX_ROWS = MAX_ROWS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [4:0]             req_cmd,
   input  logic [7:0]             req_value,
   input  logic [7:0]             req_row,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_reg_select,
   output logic [3:0]             rsp_nibble,
   output logic                   rsp_settle_after,
   output logic                   rsp_last,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [LINES_WIDTH-1:0] csr_wdata
);

   clni_ctl_type ctl;
   clni_sts_type sts;

   // The single register is a plain flop: take every write at once
   assign csr_ready = 1'b1;

   clni_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   clni_dpath #(
      .MAX_ROWS (MAX_ROWS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .req_cmd          (req_cmd),
      .req_value        (req_value),
      .req_row          (req_row),
      .csr_write        (csr_valid && csr_ready),
      .csr_wdata        (csr_wdata),
      .ctl              (ctl),
      .sts              (sts),
      .rsp_reg_select   (rsp_reg_select),
      .rsp_nibble       (rsp_nibble),
      .rsp_settle_after (rsp_settle_after),
      .rsp_last         (rsp_last)
   );

endmodule

>>> sv/clni_checker.sv
// Port-level checks for char_lcd_nibble_interface_unit, bound to the top.
// Depends on clni_pkg.
`timescale 1ns / 1ps

module clni_checker
   import clni_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [4:0] req_cmd,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_reg_select,
   input logic [3:0] rsp_nibble,
   input logic       rsp_settle_after,
   input logic       rsp_last
);

   // a stalled strobe holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_nibble)
         && $stable(rsp_reg_select) && $stable(rsp_last))
      else $error("stalled strobe changed");

   // a real operation makes the block busy
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_cmd <= CMD_GLYPH_ADDR |=> !req_ready)
      else $error("new word taken during an operation");

   // no new word while a non-final strobe goes out
   a_mid_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("ready in the middle of a strobe sequence");

   // character data never asks for a settle delay
   a_data_settle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_reg_select |-> !rsp_settle_after)
      else $error("settle mark on a data strobe");

endmodule

bind char_lcd_nibble_interface_unit clni_checker u_clni_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .req_cmd          (req_cmd),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_reg_select   (rsp_reg_select),
   .rsp_nibble       (rsp_nibble),
   .rsp_settle_after (rsp_settle_after),
   .rsp_last         (rsp_last)
);

>>> tb/sv/tb.sv
// Self-checking testbench for char_lcd_nibble_interface_unit.
// Depends on clni_pkg and the unit; predicts each enable strobe and checks it in order.
`timescale 1ns / 1ps

module tb;
   import clni_pkg::*;

   // LCD instruction bytes and the wake-up nibbles of the 4-bit init sequence
   localparam logic [7:0] INSTR_CLEAR  = 8'h01;
   localparam logic [7:0] INSTR_HOME   = 8'h02;
   localparam logic [7:0] LCD_ENTRY    = 8'h04;
   localparam logic [7:0] LCD_DISPLAY  = 8'h08;
   localparam logic [7:0] LCD_SHIFT_L  = 8'h18;
   localparam logic [7:0] LCD_SHIFT_R  = 8'h1C;
   localparam logic [7:0] LCD_FUNC_SET = 8'h20;
   localparam logic [7:0] LCD_CGRAM    = 8'h40;
   localparam logic [7:0] LCD_DDRAM    = 8'h80;
   localparam logic [3:0] WAKE_NIBBLE  = 4'h3;
   localparam logic [3:0] BUS4_NIBBLE  = 4'h2;
   localparam logic [2:0] DISP_ON_BIT  = 3'h4;
   localparam logic [2:0] CURS_ON_BIT  = 3'h2;
   localparam logic [2:0] BLINK_ON_BIT = 3'h1;
   localparam logic [1:0] LTR_BIT      = 2'h2;
   localparam logic [1:0] AUTO_BIT     = 2'h1;

   // cmd codes past the last operation; the unit drops them
   localparam logic [4:0] CMD_UNKNOWN_LO = 5'd18;
   localparam logic [4:0] CMD_UNKNOWN_HI = 5'd31;

   localparam int REPORT_LIMIT   = 10;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 16;
   localparam int LONG_HOLD      = 48;
   localparam int PHASE_ITEMS    = 24;

   typedef struct packed {
      logic       reg_select;
      logic [3:0] nibble;
      logic       settle_after;
      logic       last;
   } strobe_word;

   // Expected-strobe ledger: mirrors the flag registers and lines_in_use, expands each
   // accepted operation into its strobes, and checks delivered strobes in order.
   class lcd_strobe_ledger;
      logic [LINES_WIDTH-1:0] lines_in_use;
      logic [2:0]             display_flags;
      logic [1:0]             entry_flags;
      strobe_word             strobes_due[$];
      int                     mismatches;

      function new();
         lines_in_use  = LINES_RESET;
         display_flags = '0;
         entry_flags   = '0;
         mismatches    = 0;
      endfunction

      function void set_lines(input logic [LINES_WIDTH-1:0] n);
         lines_in_use = n;
      endfunction

      function int outstanding();
         return strobes_due.size();
      endfunction

      function void push_nibble(input logic rs, input logic [3:0] nib, input logic settle);
         strobe_word s;
         s.reg_select   = rs;
         s.nibble       = nib;
         s.settle_after = settle;
         s.last         = 1'b0;
         strobes_due.push_back(s);
      endfunction

      // high nibble first; only the low nibble can carry the settle mark
      function void push_byte(input logic rs, input logic [7:0] cmd_byte, input logic settle);
         push_nibble(rs, cmd_byte[7:4], 1'b0);
         push_nibble(rs, cmd_byte[3:0], settle);
      endfunction

      function logic [7:0] row_offset(input int unsigned r);
         case (r)
            0: return 8'd0;
            1: return 8'd64;
            2: return 8'd16;
            default: return 8'd80;
         endcase
      endfunction

      function void take_request(input logic [4:0] cmd, input logic [7:0] value,
                                 input logic [7:0] row);
         int          first;
         int unsigned lines;
         int unsigned r;
         logic [2:0]  dbit;
         logic [1:0]  ebit;
         logic [7:0]  addr;
         first = strobes_due.size();
         case (cmd)
            CMD_INIT: begin
               push_nibble(1'b0, WAKE_NIBBLE, 1'b1);
               push_nibble(1'b0, WAKE_NIBBLE, 1'b1);
               push_nibble(1'b0, WAKE_NIBBLE, 1'b1);
               push_nibble(1'b0, BUS4_NIBBLE, 1'b0);
               push_byte(1'b0, LCD_FUNC_SET, 1'b0);
               display_flags = DISP_ON_BIT;
               push_byte(1'b0, LCD_DISPLAY | display_flags, 1'b0);
               push_byte(1'b0, INSTR_CLEAR, 1'b1);
               entry_flags = LTR_BIT;
               push_byte(1'b0, LCD_ENTRY | entry_flags, 1'b0);
            end
            CMD_CLEAR: push_byte(1'b0, INSTR_CLEAR, 1'b1);
            CMD_HOME:  push_byte(1'b0, INSTR_HOME, 1'b1);
            CMD_CURSOR: begin
               lines = (lines_in_use == 0) ? 1 : lines_in_use;
               r = row;
               if (r > MAX_ROWS_DEFAULT - 1) r = MAX_ROWS_DEFAULT - 1;
               if (r >= lines) r = lines - 1;
               addr = (value + row_offset(r)) & 8'h7F;
               push_byte(1'b0, LCD_DDRAM | addr, 1'b0);
            end
            CMD_DISP_OFF, CMD_DISP_ON, CMD_CURS_OFF,
            CMD_CURS_ON, CMD_BLINK_OFF, CMD_BLINK_ON: begin
               dbit = (cmd <= CMD_DISP_ON) ? DISP_ON_BIT :
                      (cmd <= CMD_CURS_ON) ? CURS_ON_BIT : BLINK_ON_BIT;
               if (cmd[0]) display_flags = display_flags | dbit;
               else        display_flags = display_flags & ~dbit;
               push_byte(1'b0, LCD_DISPLAY | display_flags, 1'b0);
            end
            CMD_SCROLL_L: push_byte(1'b0, LCD_SHIFT_L, 1'b0);
            CMD_SCROLL_R: push_byte(1'b0, LCD_SHIFT_R, 1'b0);
            CMD_ENTRY_LTR, CMD_ENTRY_RTL, CMD_AUTO_ON, CMD_AUTO_OFF: begin
               ebit = (cmd <= CMD_ENTRY_RTL) ? LTR_BIT : AUTO_BIT;
               if (!cmd[0]) entry_flags = entry_flags | ebit;
               else         entry_flags = entry_flags & ~ebit;
               push_byte(1'b0, LCD_ENTRY | entry_flags, 1'b0);
            end
            CMD_CHAR:       push_byte(1'b1, value, 1'b0);
            CMD_GLYPH_ADDR: push_byte(1'b0, LCD_CGRAM | {2'b00, value[2:0], 3'b000}, 1'b0);
            default: ;
         endcase
         if (strobes_due.size() > first) strobes_due[strobes_due.size() - 1].last = 1'b1;
      endfunction

      function void check_strobe(input strobe_word got);
         strobe_word want;
         if (strobes_due.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: unexpected strobe rs=%0b nib=%h settle=%0b last=%0b", $realtime,
                        got.reg_select, got.nibble, got.settle_after, got.last);
            return;
         end
         want = strobes_due.pop_front();
         if (want.reg_select !== got.reg_select || want.nibble !== got.nibble ||
             want.settle_after !== got.settle_after || want.last !== got.last) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: strobe mismatch exp rs=%0b nib=%h settle=%0b last=%0b,",
                        $realtime, want.reg_select, want.nibble, want.settle_after, want.last,
                        " got rs=%0b nib=%h settle=%0b last=%0b",
                        got.reg_select, got.nibble, got.settle_after, got.last);
         end
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [4:0]             req_cmd;
   logic [7:0]             req_value;
   logic [7:0]             req_row;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic                   rsp_reg_select;
   logic [3:0]             rsp_nibble;
   logic                   rsp_settle_after;
   logic                   rsp_last;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [LINES_WIDTH-1:0] csr_wdata;

   lcd_strobe_ledger ledger;
   int  idle_cycles;
   bit  sender_gaps;    // random gaps before request words
   bit  quiet_tail;     // last phase: neither side idles
   bit  hold_off_req;   // ask the receiver for one long stall

   char_lcd_nibble_interface_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_value        (req_value),
      .req_row          (req_row),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_reg_select   (rsp_reg_select),
      .rsp_nibble       (rsp_nibble),
      .rsp_settle_after (rsp_settle_after),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Monitor: every handshake is seen with pre-edge values. Requests are noted before
   // strobes are checked so that the ledger always runs ahead of the unit.
   initial begin
      ledger = new();
      idle_cycles = 0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) ledger.set_lines(csr_wdata);
         if (req_valid && req_ready) ledger.take_request(req_cmd, req_value, req_row);
         if (rsp_valid && rsp_ready)
            ledger.check_strobe('{rsp_reg_select, rsp_nibble, rsp_settle_after, rsp_last});
         if ((csr_valid && csr_ready) || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
   end

   // Watchdog: end the run if nothing moves on any channel for too long
   initial begin
      @(negedge reset);
      while (idle_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("Simulation FAILED");
      $finish;
   end

   // Receiver: random stall bursts, runs of steady ready, one long hold on request.
   // Each pass assigns rsp_ready once at an edge, then holds it for the chosen count.
   initial begin
      rsp_ready <= 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            rsp_ready <= 1'b0;
            hold_off_req = 1'b0;
            repeat (LONG_HOLD - 1) @(posedge clock);
         end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 11) - 1) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            if (!quiet_tail) repeat ($urandom_range(0, 15)) @(posedge clock);
         end
      end
   end

   function automatic logic [7:0] rand8();
      return 8'($urandom_range(0, 255));
   endfunction

   // mostly rows near the configured range, now and then any byte
   function automatic logic [7:0] pick_row();
      if ($urandom_range(0, 3) == 0) return rand8();
      return 8'($urandom_range(0, 7));
   endfunction

   // Offer one request word and hold it until taken. Called at a clock edge; returns at
   // the edge where the word was accepted, so back-to-back words keep req_valid high.
   task automatic send_request(input logic [4:0] cmd, input logic [7:0] value,
                               input logic [7:0] row);
      if (sender_gaps && !quiet_tail && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd   <= cmd;
      req_value <= value;
      req_row   <= row;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic write_lines(input logic [LINES_WIDTH-1:0] n);
      csr_valid <= 1'b1;
      csr_wdata <= n;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // Drop valid, let the monitor log the last accepted word, drain every expected
   // strobe, then give the sequencer time to go idle
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (ledger.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Random traffic, weighted toward realistic sequences: glyph uploads (address then
   // eight pattern rows) and cursor moves followed by text. Dropped cmds don't count.
   task automatic send_random_items(input int count);
      int         done_items;
      int         roll;
      int         n;
      logic [4:0] cmd;
      done_items = 0;
      while (done_items < count) begin
         roll = $urandom_range(0, 99);
         if (roll < 8) begin
            send_request(CMD_GLYPH_ADDR, rand8(), rand8());
            repeat (8) send_request(CMD_CHAR, rand8(), rand8());
            done_items += 9;
         end else if (roll < 20) begin
            n = $urandom_range(1, 6);
            send_request(CMD_CURSOR, rand8(), pick_row());
            repeat (n) send_request(CMD_CHAR, rand8(), rand8());
            done_items += n + 1;
         end else if (roll < 24) begin
            send_request(CMD_INIT, rand8(), rand8());
            done_items++;
         end else if (roll < 32) begin
            send_request(5'($urandom_range(CMD_UNKNOWN_LO, CMD_UNKNOWN_HI)), rand8(), rand8());
         end else begin
            cmd = 5'($urandom_range(CMD_CLEAR, CMD_GLYPH_ADDR));
            send_request(cmd, rand8(), (cmd == CMD_CURSOR) ? pick_row() : rand8());
            done_items++;
         end
      end
   endtask

   initial begin
      int phase_lines[8] = '{1, 0, 7, 2, 3, 5, 6, 4};
      int failures;
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_cmd      <= '0;
      req_value    <= '0;
      req_row      <= '0;
      csr_valid    <= 1'b0;
      csr_wdata    <= '0;
      sender_gaps  = 1'b1;
      quiet_tail   = 1'b0;
      hold_off_req = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: every operation once, field extremes, row clamp, dropped cmd codes
      write_lines(3'd4);
      send_request(CMD_INIT, 8'h00, 8'h00);
      send_request(CMD_CLEAR, 8'hFF, 8'hFF);
      send_request(CMD_HOME, 8'h00, 8'h00);
      send_request(CMD_CURSOR, 8'h00, 8'h00);
      send_request(CMD_CURSOR, 8'hFF, 8'hFF);
      for (int c = CMD_DISP_OFF; c <= CMD_AUTO_OFF; c++)
         send_request(5'(c), rand8(), rand8());
      send_request(CMD_CHAR, 8'h00, 8'h00);
      send_request(CMD_CHAR, 8'hFF, 8'hFF);
      send_request(CMD_GLYPH_ADDR, 8'h00, 8'h00);
      send_request(CMD_GLYPH_ADDR, 8'hFF, 8'hFF);
      send_request(CMD_UNKNOWN_LO, 8'h00, 8'h00);
      send_request(CMD_UNKNOWN_HI, 8'hFF, 8'hFF);
      drain();

      // Random phases, each under its own row count, including zero and out-of-range
      for (int p = 0; p < 8; p++) begin
         write_lines(phase_lines[p][LINES_WIDTH-1:0]);
         if (p == 2) begin
            // stall the receiver and keep offering words back to back until input backs up
            hold_off_req = 1'b1;
            sender_gaps  = 1'b0;
            send_random_items(16);
            sender_gaps  = 1'b1;
         end
         if (p == 7) quiet_tail = 1'b1;
         send_random_items(PHASE_ITEMS);
         drain();
      end

      failures = ledger.mismatches + ledger.outstanding();
      if (failures == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
